// ----- rtl/core/cpie_pkg.sv -----
// Shared types and constants for the controller packet to input events block.
`timescale 1ns / 1ps
package cpie_pkg;

	// Opcodes
	localparam logic [1:0] OP_DECODE  = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	// Packet lengths
	localparam logic [1:0] PKT_5  = 2'd0;
	localparam logic [1:0] PKT_9  = 2'd1;
	localparam logic [1:0] PKT_16 = 2'd2;
	localparam logic [1:0] PKT_BAD = 2'd3;

	// Result kinds
	localparam logic [2:0] EV_REPORT = 3'd0;
	localparam logic [2:0] EV_MOVE   = 3'd1;
	localparam logic [2:0] EV_BUTTON = 3'd2;
	localparam logic [2:0] EV_KEYUP  = 3'd3;
	localparam logic [2:0] EV_KEYDN  = 3'd4;

	// Button codes
	localparam logic [7:0] BTN_NONE   = 8'd0;
	localparam logic [7:0] BTN_L_DOWN = 8'd1;
	localparam logic [7:0] BTN_L_UP   = 8'd2;
	localparam logic [7:0] BTN_R_DOWN = 8'd3;
	localparam logic [7:0] BTN_R_UP   = 8'd4;
	localparam logic [7:0] BTN_M_DOWN = 8'd5;
	localparam logic [7:0] BTN_M_UP   = 8'd6;

	// Click byte values
	localparam logic [7:0] CLICK_LEFT   = 8'd1;
	localparam logic [7:0] CLICK_RIGHT  = 8'd2;
	localparam logic [7:0] CLICK_MIDDLE = 8'd3;

	// Neutral stick / mouse byte
	localparam logic [7:0] BYTE_CENTER = 8'd128;

	// Pending-word slots, emitted lowest first
	localparam int NUM_EV = 11;
	localparam logic [3:0] BIT_LEAD   = 4'd0;  // mouse move, or leading report on release
	localparam logic [3:0] BIT_BUTTON = 4'd1;
	localparam logic [3:0] BIT_UP0    = 4'd2;
	localparam logic [3:0] BIT_UP3    = 4'd5;
	localparam logic [3:0] BIT_DN0    = 4'd6;
	localparam logic [3:0] BIT_DN3    = 4'd9;
	localparam logic [3:0] BIT_REPORT = 4'd10;

	// One decoded item waiting to be emitted
	typedef struct packed {
		logic [NUM_EV-1:0] pend;
		logic              lead_rep;
		logic signed [15:0] lx;
		logic signed [15:0] ly;
		logic signed [15:0] rx;
		logic signed [15:0] ry;
		logic [7:0]        rt;
		logic [7:0]        lt;
		logic [15:0]       btn;
		logic signed [8:0] dx;
		logic signed [8:0] dy;
		logic [7:0]        bcode;
		logic [31:0]       old_keys;
		logic [31:0]       new_keys;
	} cpie_job_t;

endpackage

// ----- rtl/core/cpie_key_lane.sv -----
// One key lane: flags a nonzero key code that is missing from a set of four.
`timescale 1ns / 1ps
module cpie_key_lane (
	input  logic [7:0]  key,
	input  logic [31:0] set,
	output logic        hit
);
	logic found;

	// compare against all four bytes of the set
	always_comb begin
		found = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (set[8*i +: 8] == key) begin
				found = 1'b1;
			end
		end
	end

	assign hit = (key != 8'd0) && !found;

endmodule

// ----- rtl/core/cpie_decode.sv -----
// Slot state and item decode: builds the pending event word for one item.
`timescale 1ns / 1ps
module cpie_decode #(
	parameter int MAX_SLOTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         op,
	input  logic [1:0]         slot_index,
	input  logic               slot_active,
	input  logic [1:0]         pkt_kind,
	input  logic [39:0]        base_bytes,
	input  logic [31:0]        stick_bytes,
	input  logic [23:0]        mouse_bytes,
	input  logic [31:0]        key_bytes,
	input  logic [2:0]         slot_count,
	output cpie_pkg::cpie_job_t job
);
	import cpie_pkg::*;

	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam logic [4:0] MAX_C = 5'(MAX_SLOTS);

	logic [7:0]    click_q [MAX_SLOTS];
	logic [31:0]   keys_q  [MAX_SLOTS];
	logic [SW+1:0] sidx_w;
	logic [SW-1:0] sidx;
	logic [4:0]    limit;
	logic          in_range;
	logic          do_dec;
	logic          do_rel;
	logic          do_clr;
	logic          full;
	logic [7:0]    old_click;
	logic [31:0]   old_keys;
	logic [31:0]   up_set;
	logic [3:0]    up_hit;
	logic [3:0]    dn_hit;
	logic [7:0]    b0, b1, b2, b3, b4, b5, b6, b7, b8;
	logic [7:0]    mx, my, cur;
	logic          stick_moved;
	logic          mouse_moved;
	logic          click_chg;
	logic [7:0]    code;

	// slot addressing and range check
	assign sidx_w   = {{SW{1'b0}}, slot_index};
	assign sidx     = sidx_w[SW-1:0];
	assign limit    = ({2'b00, slot_count} > MAX_C) ? MAX_C : {2'b00, slot_count};
	assign in_range = ({3'b000, slot_index} < limit);

	assign do_dec = in_range && slot_active && (op == OP_DECODE) && (pkt_kind != PKT_BAD);
	assign do_rel = in_range && slot_active && (op == OP_RELEASE);
	assign do_clr = in_range && (op == OP_CLEAR);
	assign full   = do_dec && (pkt_kind == PKT_16);

	assign old_click = click_q[sidx];
	assign old_keys  = keys_q[sidx];

	// packet bytes
	assign b0 = base_bytes[7:0];
	assign b1 = base_bytes[15:8];
	assign b2 = base_bytes[23:16];
	assign b3 = base_bytes[31:24];
	assign b4 = base_bytes[39:32];
	assign b5 = stick_bytes[7:0];
	assign b6 = stick_bytes[15:8];
	assign b7 = stick_bytes[23:16];
	assign b8 = stick_bytes[31:24];
	assign mx  = mouse_bytes[7:0];
	assign my  = mouse_bytes[15:8];
	assign cur = mouse_bytes[23:16];

	assign stick_moved = (b5 != BYTE_CENTER) || (b6 != BYTE_CENTER);
	assign mouse_moved = (mx != BYTE_CENTER) || (my != BYTE_CENTER);
	assign click_chg   = (cur != old_click);

	// key lanes: release compares against an empty set so every held key goes up
	assign up_set = do_rel ? 32'd0 : key_bytes;

	for (genvar g = 0; g < 4; g++) begin : g_lane
		cpie_key_lane u_up (
			.key (old_keys[8*g +: 8]),
			.set (up_set),
			.hit (up_hit[g])
		);
		cpie_key_lane u_dn (
			.key (key_bytes[8*g +: 8]),
			.set (old_keys),
			.hit (dn_hit[g])
		);
	end

	// button code, later steps override earlier ones
	always_comb begin
		code = BTN_NONE;
		if (cur == CLICK_LEFT) code = BTN_L_DOWN;
		else if (old_click == CLICK_LEFT) code = BTN_L_UP;
		if (cur == CLICK_RIGHT) code = BTN_R_DOWN;
		else if (old_click == CLICK_RIGHT) code = BTN_R_UP;
		if (cur == CLICK_MIDDLE) code = BTN_M_DOWN;
		else if (old_click == CLICK_MIDDLE) code = BTN_M_UP;
	end

	// job word
	always_comb begin
		job = '0;
		job.lead_rep = do_rel;
		job.old_keys = old_keys;
		job.new_keys = key_bytes;
		job.pend[BIT_LEAD]   = do_rel || (full && mouse_moved);
		job.pend[BIT_BUTTON] = full && click_chg;
		job.pend[BIT_UP3:BIT_UP0] = (do_rel || full) ? up_hit : 4'd0;
		job.pend[BIT_DN3:BIT_DN0] = full ? dn_hit : 4'd0;
		job.pend[BIT_REPORT] = do_dec;
		job.bcode = code;
		job.dx = {mx ^ BYTE_CENTER, 1'b0};
		job.dy = {my ^ BYTE_CENTER, 1'b0};
		if (do_dec) begin
			job.lx  = {b0 ^ BYTE_CENTER, 8'd0};
			job.rt  = b1;
			job.lt  = b2;
			job.btn = {b3, b4};
			if (pkt_kind != PKT_5) begin
				if (stick_moved) begin
					job.lx = {b5 ^ BYTE_CENTER, 8'd0};
					job.ly = {BYTE_CENTER - b6, 8'd0};
				end
				job.rx = {b7 ^ BYTE_CENTER, 8'd0};
				job.ry = {BYTE_CENTER - b8, 8'd0};
			end
		end
	end

	// slot state update on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				click_q[i] <= 8'd0;
				keys_q[i]  <= 32'd0;
			end
		end else if (accept) begin
			if (do_clr || do_rel) begin
				click_q[sidx] <= 8'd0;
				keys_q[sidx]  <= 32'd0;
			end else if (full) begin
				click_q[sidx] <= cur;
				keys_q[sidx]  <= key_bytes;
			end
		end
	end

endmodule

// ----- rtl/core/cpie_emit.sv -----
// Merge stage: walks a job's pending word, one result per cycle unless stalled.
`timescale 1ns / 1ps
module cpie_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  cpie_pkg::cpie_job_t job,
	input  logic                m_tready,
	output logic                m_tvalid,
	output logic [127:0]        m_tdata,   // lx, ly, rx, ry, rt, lt, btn, dx, dy, code
	output logic [2:0]          m_tuser,   // event_kind
	output logic                m_tlast,
	output logic                idle_next
);
	import cpie_pkg::*;

	cpie_job_t          job_s1;
	logic [NUM_EV-1:0]  pend_s1;
	logic [NUM_EV-1:0]  pick;
	logic [NUM_EV-1:0]  pend_after;
	logic [3:0]         idx;
	logic [3:0]         up_off;
	logic [3:0]         dn_off;
	logic               fire;

	logic               out_valid_q;
	logic [2:0]         kind_q;
	logic signed [15:0] lx_q, ly_q, rx_q, ry_q;
	logic [7:0]         rt_q, lt_q, code_q;
	logic [15:0]        btn_q;
	logic signed [8:0]  dx_q, dy_q;
	logic               last_q;

	// lowest pending slot goes next
	assign pick = pend_s1 & (~pend_s1 + NUM_EV'(1));
	always_comb begin
		idx = '0;
		for (int i = NUM_EV - 1; i >= 0; i--) begin
			if (pend_s1[i]) begin
				idx = 4'(i);
			end
		end
	end

	assign fire       = (|pend_s1) && (!out_valid_q || m_tready);
	assign pend_after = fire ? (pend_s1 & ~pick) : pend_s1;
	assign idle_next  = (pend_after == '0);
	assign up_off     = idx - BIT_UP0;
	assign dn_off     = idx - BIT_DN0;

	// job register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (load) begin
			pend_s1 <= job.pend;
		end else begin
			pend_s1 <= pend_after;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q <= EV_REPORT;
			lx_q   <= '0;
			ly_q   <= '0;
			rx_q   <= '0;
			ry_q   <= '0;
			rt_q   <= '0;
			lt_q   <= '0;
			btn_q  <= '0;
			dx_q   <= '0;
			dy_q   <= '0;
			code_q <= '0;
			last_q <= (pend_after == '0);
			case (idx) inside
				BIT_LEAD: begin
					if (!job_s1.lead_rep) begin
						kind_q <= EV_MOVE;
						dx_q   <= job_s1.dx;
						dy_q   <= job_s1.dy;
					end
				end
				BIT_BUTTON: begin
					kind_q <= EV_BUTTON;
					code_q <= job_s1.bcode;
				end
				[BIT_UP0:BIT_UP3]: begin
					kind_q <= EV_KEYUP;
					code_q <= job_s1.old_keys[{up_off[1:0], 3'b000} +: 8];
				end
				[BIT_DN0:BIT_DN3]: begin
					kind_q <= EV_KEYDN;
					code_q <= job_s1.new_keys[{dn_off[1:0], 3'b000} +: 8];
				end
				default: begin
					lx_q  <= job_s1.lx;
					ly_q  <= job_s1.ly;
					rx_q  <= job_s1.rx;
					ry_q  <= job_s1.ry;
					rt_q  <= job_s1.rt;
					lt_q  <= job_s1.lt;
					btn_q <= job_s1.btn;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {6'd0, code_q, dy_q, dx_q, btn_q, lt_q, rt_q, ry_q, rx_q, ly_q, lx_q};

`ifndef NO_ASSERTIONS
	// the final pending slot of a job is flagged as last
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (pend_after == '0) |=> m_tlast)
		else $error("last result of a run not flagged");

	// every job that emits anything carries a report
	a_has_report: assert property (@(posedge clk) disable iff (!arst_n)
		load && (|job.pend) |-> job.pend[BIT_LEAD] || job.pend[BIT_REPORT])
		else $error("job without a report");

	// a release job never holds a trailing report
	a_rel_order: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1[BIT_REPORT] |-> !job_s1.lead_rep)
		else $error("trailing report on a release job");
`endif

endmodule

// ----- rtl/core/controller_packet_to_input_events.sv -----
// Controller packet to input events: top level.
// Usage:
//   Slave stream (s_*) carries one controller item per word: op and packet length in
//   tuser, slot and packet bytes in tdata. Master stream (m_*) carries result words,
//   event kind in tuser, tlast set on the final result of an item.
//   cfg_valid/cfg_data write slot_count; cfg_ready is always high.
// Flow:
//   An accepted item is decoded in the cycle it is taken; its job word goes into
//   the job register, and each of its results (up to 11) passes from there through
//   the output register to the master side. Results leave one per cycle unless
//   m_tready stalls them. The next item is taken in the cycle its predecessor's last
//   result enters the output register; an item with no result leaves s_tready high.
// Reset:
//   All slot state (held click, held keys) clears, slot_count returns to 1 and the
//   output side is empty.
// Stall:
//   While m_tready is low the output word holds and the emitter waits; once its
//   pending results are stuck, s_tready drops until they drain.
`timescale 1ns / 1ps
module controller_packet_to_input_events #(
	parameter int MAX_SLOTS = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // slot_index, slot_active, base, stick, mouse, keys
	input  logic [3:0]   s_tuser,   // op, pkt_kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // lx, ly, rx, ry, rt, lt, btn, dx, dy, code
	output logic [2:0]   m_tuser,   // event_kind
	output logic         m_tlast,   // last_of_run
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_data   // slot_count
);
	import cpie_pkg::*;

	logic       accept;
	logic       idle_next;
	logic [2:0] slot_count_q;
	cpie_job_t  job;

	assign s_tready  = idle_next;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// slot count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			slot_count_q <= cfg_data;
		end
	end

	cpie_decode #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (s_tuser[1:0]),
		.slot_index  (s_tdata[1:0]),
		.slot_active (s_tdata[2]),
		.pkt_kind    (s_tuser[3:2]),
		.base_bytes  (s_tdata[42:3]),
		.stick_bytes (s_tdata[74:43]),
		.mouse_bytes (s_tdata[98:75]),
		.key_bytes   (s_tdata[130:99]),
		.slot_count  (slot_count_q),
		.job         (job)
	);

	cpie_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.job       (job),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.idle_next (idle_next)
	);

endmodule

// ----- bench/controller_packet_to_input_events_checker.sv -----
// Checker: watches the item, result and config channels, predicts result words and compares.
`timescale 1ns / 1ps
module controller_packet_to_input_events_checker #(
	parameter int SLOT_CAP = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [135:0] s_tdata,   // slot_index, slot_active, base, stick, mouse, keys
	input  logic [3:0]   s_tuser,   // op, pkt_kind
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,   // lx, ly, rx, ry, rt, lt, btn, dx, dy, code
	input  logic [2:0]   m_tuser,   // event_kind
	input  logic         m_tlast,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_data,
	output int           fail_count,
	output int           outstanding
);
	import cpie_pkg::*;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] lx;
		logic [15:0] ly;
		logic [15:0] rx;
		logic [15:0] ry;
		logic [7:0]  rt;
		logic [7:0]  lt;
		logic [15:0] btn;
		logic [8:0]  dx;
		logic [8:0]  dy;
		logic [7:0]  code;
		logic        last;
	} input_event_t;

	// Shadow of the per-slot state and the slot_count register
	logic [7:0]   click_held [SLOT_CAP];
	logic [31:0]  keys_held [SLOT_CAP];
	logic [2:0]   slots_in_use = 3'd1;
	input_event_t expected_events [$];
	int           mismatches = 0;

	function automatic input_event_t plain_event(logic [2:0] kind, logic [7:0] code);
		input_event_t ev;
		ev = '0;
		ev.kind = kind;
		ev.code = code;
		return ev;
	endfunction

	function automatic bit has_key(logic [31:0] set, logic [7:0] code);
		for (int i = 0; i < 4; i++)
			if (set[8*i +: 8] == code)
				return 1'b1;
		return 1'b0;
	endfunction

	// Work out the words one item causes, update the shadow state, queue the words
	task automatic predict_item(input logic [1:0] op, input logic [1:0] slot,
			input logic active, input logic [1:0] kind, input logic [39:0] base,
			input logic [31:0] stick, input logic [23:0] mouse, input logic [31:0] keys);
		input_event_t run [$];
		input_event_t ev;
		input_event_t rep;
		logic [2:0]   in_use;
		logic [7:0]   b5, b6, mx, my, cur, prev, code, k;
		logic [31:0]  old;
		in_use = (slots_in_use < 3'd4) ? slots_in_use : 3'd4;
		if ({1'b0, slot} >= in_use) begin
			// out of range: nothing at all
		end else if (op == OP_CLEAR) begin
			click_held[slot] = '0;
			keys_held[slot] = '0;
		end else if (op == OP_RELEASE && active) begin
			run.insert(run.size(), plain_event(EV_REPORT, 8'd0));
			for (int i = 0; i < 4; i++) begin
				k = keys_held[slot][8*i +: 8];
				if (k != 8'd0)
					run.insert(run.size(), plain_event(EV_KEYUP, k));
			end
			click_held[slot] = '0;
			keys_held[slot] = '0;
		end else if (op == OP_DECODE && active && kind != PKT_BAD) begin
			rep = '0;
			rep.kind = EV_REPORT;
			rep.lx = {base[7:0] - BYTE_CENTER, 8'h00};
			rep.rt = base[15:8];
			rep.lt = base[23:16];
			rep.btn = {base[31:24], base[39:32]};
			if (kind == PKT_9 || kind == PKT_16) begin
				b5 = stick[7:0];
				b6 = stick[15:8];
				if (b5 != BYTE_CENTER || b6 != BYTE_CENTER) begin
					rep.lx = {b5 - BYTE_CENTER, 8'h00};
					rep.ly = {BYTE_CENTER - b6, 8'h00};
				end
				rep.rx = {stick[23:16] - BYTE_CENTER, 8'h00};
				rep.ry = {BYTE_CENTER - stick[31:24], 8'h00};
			end
			if (kind == PKT_16) begin
				mx = mouse[7:0];
				my = mouse[15:8];
				cur = mouse[23:16];
				prev = click_held[slot];
				old = keys_held[slot];
				if (mx != BYTE_CENTER || my != BYTE_CENTER) begin
					ev = plain_event(EV_MOVE, 8'd0);
					ev.dx = {mx - BYTE_CENTER, 1'b0};
					ev.dy = {my - BYTE_CENTER, 1'b0};
					run.insert(run.size(), ev);
				end
				// each button step overrides the earlier ones
				if (cur != prev) begin
					code = BTN_NONE;
					if (cur == CLICK_LEFT) code = BTN_L_DOWN;
					else if (prev == CLICK_LEFT) code = BTN_L_UP;
					if (cur == CLICK_RIGHT) code = BTN_R_DOWN;
					else if (prev == CLICK_RIGHT) code = BTN_R_UP;
					if (cur == CLICK_MIDDLE) code = BTN_M_DOWN;
					else if (prev == CLICK_MIDDLE) code = BTN_M_UP;
					run.insert(run.size(), plain_event(EV_BUTTON, code));
					click_held[slot] = cur;
				end
				for (int i = 0; i < 4; i++) begin
					k = old[8*i +: 8];
					if (k != 8'd0 && !has_key(keys, k))
						run.insert(run.size(), plain_event(EV_KEYUP, k));
				end
				for (int i = 0; i < 4; i++) begin
					k = keys[8*i +: 8];
					if (k != 8'd0 && !has_key(old, k))
						run.insert(run.size(), plain_event(EV_KEYDN, k));
				end
				keys_held[slot] = keys;
			end
			run.insert(run.size(), rep);
		end
		if (run.size() > 0) begin
			ev = run.pop_back();
			ev.last = 1'b1;
			run.insert(run.size(), ev);
			foreach (run[i])
				expected_events.insert(expected_events.size(), run[i]);
		end
	endtask

	task automatic check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		input_event_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_CAP; i++) begin
				click_held[i] = '0;
				keys_held[i] = '0;
			end
			slots_in_use = 3'd1;
			expected_events.delete();
		end else begin
			// result side first: a word never belongs to an item taken at the same edge
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					$error("event_kind: expected nothing, got %0d", m_tuser);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_kind", 16'(want.kind), 16'(m_tuser));
					check_field("thumb_lx", want.lx, m_tdata[15:0]);
					check_field("thumb_ly", want.ly, m_tdata[31:16]);
					check_field("thumb_rx", want.rx, m_tdata[47:32]);
					check_field("thumb_ry", want.ry, m_tdata[63:48]);
					check_field("right_trigger", 16'(want.rt), 16'(m_tdata[71:64]));
					check_field("left_trigger", 16'(want.lt), 16'(m_tdata[79:72]));
					check_field("button_mask", want.btn, m_tdata[95:80]);
					check_field("mouse_dx", 16'(want.dx), 16'(m_tdata[104:96]));
					check_field("mouse_dy", 16'(want.dy), 16'(m_tdata[113:105]));
					check_field("event_code", 16'(want.code), 16'(m_tdata[121:114]));
					check_field("last_of_run", 16'(want.last), 16'(m_tlast));
				end
			end
			if (cfg_valid && cfg_ready)
				slots_in_use = cfg_data;
			if (s_tvalid && s_tready)
				predict_item(s_tuser[1:0], s_tdata[1:0], s_tdata[2], s_tuser[3:2],
					s_tdata[42:3], s_tdata[74:43], s_tdata[98:75], s_tdata[130:99]);
		end
		fail_count <= mismatches;
		outstanding <= expected_events.size();
	end

endmodule

// ----- bench/controller_packet_to_input_events_tb.sv -----
// Testbench top: clock, reset, item and config stimulus, output stalls and the verdict.
`timescale 1ns / 1ps
module controller_packet_to_input_events_tb;
	import cpie_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE_CYCLES = 16;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;   // slot_index, slot_active, base, stick, mouse, keys
	logic [3:0]   s_tuser = '0;   // op, pkt_kind
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;        // lx, ly, rx, ry, rt, lt, btn, dx, dy, code
	logic [2:0]   m_tuser;        // event_kind
	logic         m_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_data = '0;
	int           fail_count;
	int           outstanding;
	int           cycle_count = 0;
	bit           tx_quiet = 1'b0;
	logic [31:0]  sent_keys [4] = '{default: '0};

	controller_packet_to_input_events DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	controller_packet_to_input_events_checker event_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Cycle watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** controller_packet_to_input_events: FAILED **");
		$finish;
	end

	// Result side: random stall before each word, with calm stretches
	initial begin
		int  gap;
		bit  rx_quiet;
		rx_quiet = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 24) == 0)
				rx_quiet = !rx_quiet;
			gap = rx_quiet ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// One item word: optional idle gap, then hold until taken
	task automatic send_item(input logic [1:0] op, input logic [1:0] slot,
			input logic active, input logic [1:0] kind, input logic [39:0] base,
			input logic [31:0] stick, input logic [23:0] mouse, input logic [31:0] keys);
		int gap;
		if ($urandom_range(0, 24) == 0)
			tx_quiet = !tx_quiet;
		gap = tx_quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, keys, mouse, stick, base, active, slot};
		s_tuser <= {kind, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait until every predicted word has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_slot_count(input logic [2:0] value);
		drain_results();
		repeat (12) @(posedge clk);   // an item with no results may still be in work
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return 8'd0;
		else if (r < 85)
			return 8'($urandom_range(1, 8));
		return 8'($urandom);
	endfunction

	initial begin
		logic [1:0]  op, slot, kind;
		logic        active;
		logic [39:0] base;
		logic [31:0] stick, keys;
		logic [23:0] mouse;
		logic [2:0]  phase_slots;
		int          r, j, n_items;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: range limit at the reset slot count, then field extremes
		send_item(OP_DECODE, 2'd0, 1'b1, PKT_5, 40'd0, 32'd0, 24'd0, 32'd0);
		send_item(OP_DECODE, 2'd1, 1'b1, PKT_5, 40'h12_3456_789A, 32'd0, 24'd0, 32'd0);
		write_slot_count(3'd4);
		send_item(OP_DECODE, 2'd0, 1'b1, PKT_5, '1, '1, '1, '1);
		// left stick centered: steering stays in thumb_lx
		send_item(OP_DECODE, 2'd1, 1'b1, PKT_9, 40'hA5_5A3C_C3E1, 32'h1234_8080, 24'd0, 32'd0);
		send_item(OP_DECODE, 2'd1, 1'b1, PKT_9, 40'h01_0203_0405, 32'hFF00_FF80, 24'd0, 32'd0);
		// inverted axes wrap 32768 to -32768
		send_item(OP_DECODE, 2'd2, 1'b1, PKT_9, 40'd0, 32'd0, 24'd0, 32'd0);
		send_item(OP_DECODE, 2'd2, 1'b1, PKT_9, '1, '1, 24'd0, 32'd0);
		// key and button sequences on one slot
		send_item(OP_DECODE, 2'd0, 1'b1, PKT_16, '1, 32'h8080_8080, 24'h00_8080,
			32'h0403_0201);
		send_item(OP_DECODE, 2'd0, 1'b1, PKT_16, 40'd0, 32'h8080_8080, 24'h01_00FF,
			32'h0005_0201);
		send_item(OP_DECODE, 2'd0, 1'b1, PKT_16, 40'd0, 32'd0, 24'h02_8080, 32'h0005_0201);
		send_item(OP_DECODE, 2'd0, 1'b1, PKT_16, 40'd0, 32'd0, 24'h03_8080, 32'h0005_0201);
		send_item(OP_DECODE, 2'd0, 1'b1, PKT_16, 40'd0, 32'd0, 24'h00_8080, 32'h0005_0201);
		// unknown click value still gives a button word; duplicate keys each count
		send_item(OP_DECODE, 2'd0, 1'b1, PKT_16, 40'd0, 32'd0, 24'hFF_8080, 32'h0909_0909);
		// most words one item can cause
		send_item(OP_DECODE, 2'd3, 1'b1, PKT_16, 40'd0, 32'd0, 24'h00_8080, 32'h0403_0201);
		send_item(OP_DECODE, 2'd3, 1'b1, PKT_16, '1, '1, 24'h01_7F81, 32'h0807_0605);
		send_item(OP_RELEASE, 2'd3, 1'b1, PKT_16, 40'd0, 32'd0, 24'd0, 32'd0);
		// inactive release does nothing, clear ignores the active flag
		send_item(OP_RELEASE, 2'd0, 1'b0, PKT_16, 40'd0, 32'd0, 24'd0, 32'd0);
		send_item(OP_CLEAR, 2'd0, 1'b0, PKT_16, 40'd0, 32'd0, 24'd0, 32'd0);
		send_item(OP_RELEASE, 2'd0, 1'b1, PKT_16, 40'd0, 32'd0, 24'd0, 32'd0);
		send_item(OP_DECODE, 2'd1, 1'b1, PKT_BAD, '1, '1, '1, '1);
		send_item(OP_UNUSED, 2'd1, 1'b1, PKT_16, '1, '1, '1, '1);
		send_item(OP_DECODE, 2'd1, 1'b0, PKT_16, '1, '1, '1, '1);
		// release drops the held click without a button word
		send_item(OP_DECODE, 2'd0, 1'b1, PKT_16, 40'd0, 32'd0, 24'h01_8080, 32'd0);
		send_item(OP_RELEASE, 2'd0, 1'b1, PKT_5, 40'd0, 32'd0, 24'd0, 32'd0);
		send_item(OP_DECODE, 2'd0, 1'b1, PKT_16, 40'd0, 32'd0, 24'h01_8080, 32'd0);

		// Random phases over several slot counts, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: phase_slots = 3'd2;
				1: phase_slots = 3'd7;
				2: phase_slots = 3'd3;
				3: phase_slots = 3'd0;
				4: phase_slots = 3'd1;
				default: phase_slots = 3'd4;
			endcase
			write_slot_count(phase_slots);
			n_items = (phase_slots == 3'd0) ? 10 : 30;
			for (int n = 0; n < n_items; n++) begin
				r = $urandom_range(0, 99);
				if (r < 72) op = OP_DECODE;
				else if (r < 84) op = OP_RELEASE;
				else if (r < 94) op = OP_CLEAR;
				else op = OP_UNUSED;
				slot = 2'($urandom_range(0, 3));
				active = ($urandom_range(0, 9) != 0);
				r = $urandom_range(0, 99);
				if (r < 15) kind = PKT_5;
				else if (r < 30) kind = PKT_9;
				else if (r < 93) kind = PKT_16;
				else kind = PKT_BAD;
				base = {8'($urandom), 32'($urandom)};
				r = $urandom_range(0, 7);
				if (r == 0) base = '0;
				else if (r == 1) base = '1;
				stick = $urandom;
				r = $urandom_range(0, 7);
				if (r < 2) stick[15:0] = 16'h8080;
				else if (r == 2) stick = 32'h8080_8080;
				mouse = 24'($urandom);
				if ($urandom_range(0, 2) == 0)
					mouse[15:0] = 16'h8080;
				mouse[23:16] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, 3));
				// mostly keys that overlap what the slot already holds
				if ($urandom_range(0, 2) != 0) begin
					keys = sent_keys[slot];
					j = $urandom_range(0, 3);
					keys[8*j +: 8] = pick_key();
				end else begin
					for (int b = 0; b < 4; b++)
						keys[8*b +: 8] = pick_key();
				end
				if (op == OP_DECODE && active && kind == PKT_16)
					sent_keys[slot] = keys;
				else if (op == OP_CLEAR || (op == OP_RELEASE && active))
					sent_keys[slot] = '0;
				send_item(op, slot, active, kind, base, stick, mouse, keys);
				if ($urandom_range(0, 39) == 0)
					drain_results();
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("** controller_packet_to_input_events: PASSED **");
		else
			$display("** controller_packet_to_input_events: FAILED **");
		$finish;
	end

endmodule
